FILE: rtl/mmbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmbc_pkg: memory map bus with console, shared definitions
// Address map, store sizes, operation and status codes.
// ----------------------------------------------------------------------------
package mmbc_pkg;

  // Built store sizes in bytes
  localparam int unsigned PROGRAM_BYTES = 16384;
  localparam int unsigned DATA_BYTES    = 65536;

  // Stores are four byte lanes, one row per aligned word
  localparam int unsigned PROG_ROWS = (PROGRAM_BYTES + 3) / 4;
  localparam int unsigned DATA_ROWS = (DATA_BYTES + 3) / 4;
  localparam int unsigned PROW_W    = $clog2(PROG_ROWS);
  localparam int unsigned DROW_W    = $clog2(DATA_ROWS);
  localparam int unsigned CLR_ROWS  = (PROG_ROWS > DATA_ROWS) ? PROG_ROWS : DATA_ROWS;
  localparam int unsigned CLR_W     = $clog2(CLR_ROWS);

  // Address map, region ends exclusive
  localparam logic [31:0] PROG_BASE = 32'h1000_0000;
  localparam logic [31:0] DATA_BASE = 32'h2000_0000;
  localparam logic [31:0] IN_BASE   = 32'h3000_0000;
  localparam logic [31:0] OUT_BASE  = 32'h3000_0004;
  localparam logic [31:0] MAP_TOP   = 32'h3000_0008;

  typedef enum logic [2:0] {
    OP_FETCH     = 3'd0,
    OP_LOAD_WORD = 3'd1,
    OP_LOAD_BYTE = 3'd2,
    OP_STORE_WORD = 3'd3,
    OP_STORE_BYTE = 3'd4,
    OP_STORE_HALF = 3'd5,
    OP_PROG_BYTE = 3'd6,
    OP_CHAR_IN   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PENDING    = 3'd1,
    ST_CONSOLE    = 3'd2,
    ST_MISALIGNED = 3'd3,
    ST_INVALID    = 3'd4,
    ST_RANGE      = 3'd5,
    ST_HALT       = 3'd6
  } status_e;

  // Source of the returned read data
  typedef enum logic [2:0] {
    RS_LIT   = 3'd0,
    RS_PWORD = 3'd1,
    RS_DWORD = 3'd2,
    RS_PBYTE = 3'd3,
    RS_DBYTE = 3'd4
  } rsel_e;

endpackage : mmbc_pkg
`default_nettype wire

FILE: rtl/mmbc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmbc_ram: byte-wide single-port RAM
// One access per enabled cycle, read data registered.
// ----------------------------------------------------------------------------
module mmbc_ram #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [7:0]               wdata_i,
  output      logic [7:0]               rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : mmbc_ram
`default_nettype wire

FILE: rtl/memory_map_bus_with_console_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// memory_map_bus_with_console_unit: memory map bus with console port
// Decodes one processor access per request into the program store, data
// store, console input or console output port; big-endian word, byte and
// halfword accesses with status codes for errors, halt and console reads.
// ----------------------------------------------------------------------------
//
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+-------------------------------
// in      | into unit | in_valid_i / in_stall_o | op, address, write_data,
//         |           |                        | input_char
// out     | from unit | out_valid_o / out_stall_i | read_data, status,
//         |           |                        | putc_valid, putc_char
//
// One request per cycle sustained while out_stall_i is low; a result leaves
// through the input register, then store access and the result register.
// Reset starts a clearing pass over the stores, one row of four bytes per
// cycle over max(PROGRAM_BYTES, DATA_BYTES)/4 rounded up rows (16384 here);
// in_stall_o stays high until it finishes.
// A stall on the result side freezes both stages, so in_stall_o follows
// out_stall_i while a result waits.
//
module memory_map_bus_with_console_unit
  import mmbc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [7:0]  input_char_i,
  // result channel
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [31:0] read_data_o,
  output      logic [2:0]  status_o,
  output      logic        putc_valid_o,
  output      logic [7:0]  putc_char_o
);

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic adv;          // both stages move this cycle
  logic clr_busy_q;
  logic [CLR_W-1:0] clr_cnt_q;

  logic        a_valid_q;
  op_e         a_op_q;
  logic [31:0] a_addr_q;
  logic [31:0] a_wd_q;
  logic [7:0]  a_ic_q;

  logic        b_valid_q;
  status_e     b_status_q;
  rsel_e       b_rsel_q;
  logic [1:0]  b_lane_q;
  logic [7:0]  b_rlit_q;
  logic        b_putc_q;
  logic [7:0]  b_putc_char_q;

  // Console and output port state
  logic       pend_q, pend_d;
  logic [7:0] cchar_q, cchar_d;
  logic [7:0] port_q [4];
  logic [7:0] port_d [4];

  assign adv        = !(b_valid_q && out_stall_i);
  assign in_stall_o = !adv || clr_busy_q;

  // --------------------------------------------------------------------------
  // Address decode (stage A)
  // --------------------------------------------------------------------------
  logic [31:0] p_off, d_off, a_nxt, d_off_nxt;
  logic        ge_prog, ge_data, ge_data_nxt;
  logic        in_prog1, in_prog4, in_data1, in_data4, in_data1_nxt;
  logic        in_input, in_output, misal;
  status_e     fail_st, fail_st_nxt;

  assign p_off     = a_addr_q - PROG_BASE;
  assign d_off     = a_addr_q - DATA_BASE;
  assign a_nxt     = a_addr_q + 32'd1;
  assign d_off_nxt = a_nxt - DATA_BASE;

  assign ge_prog     = a_addr_q >= PROG_BASE;
  assign ge_data     = a_addr_q >= DATA_BASE;
  assign ge_data_nxt = a_nxt >= DATA_BASE;

  // Store sizes never exceed their region, so size checks bound the region too
  assign in_prog1 = ge_prog && ({1'b0, p_off} < 33'(PROGRAM_BYTES));
  assign in_prog4 = ge_prog && (({1'b0, p_off} + 33'd4) <= 33'(PROGRAM_BYTES));
  assign in_data1 = ge_data && ({1'b0, d_off} < 33'(DATA_BYTES));
  assign in_data4 = ge_data && (({1'b0, d_off} + 33'd4) <= 33'(DATA_BYTES));
  assign in_data1_nxt = ge_data_nxt && ({1'b0, d_off_nxt} < 33'(DATA_BYTES));

  assign in_input  = a_addr_q inside {[IN_BASE : OUT_BASE - 32'd1]};
  assign in_output = a_addr_q inside {[OUT_BASE : MAP_TOP - 32'd1]};
  assign misal     = a_addr_q[1:0] != 2'b00;

  assign fail_st     = (a_addr_q > MAP_TOP) ? ST_RANGE : ST_INVALID;
  assign fail_st_nxt = (a_nxt > MAP_TOP) ? ST_RANGE : ST_INVALID;

  // --------------------------------------------------------------------------
  // Access decision
  // --------------------------------------------------------------------------
  status_e     st;
  rsel_e       rsel;
  logic        con_rd;
  logic [7:0]  rlit;
  logic        emit;
  logic [3:0]  p_we, d_we;
  logic [PROW_W-1:0] p_row [4];
  logic [DROW_W-1:0] d_row [4];
  logic [7:0]  p_wdat [4];
  logic [7:0]  d_wdat [4];

  always_comb begin
    st     = ST_OK;
    rsel   = RS_LIT;
    con_rd = 1'b0;
    emit   = 1'b0;
    p_we   = '0;
    d_we   = '0;
    cchar_d = cchar_q;
    for (int k = 0; k < 4; k++) begin
      p_row[k]  = p_off[PROW_W+1:2];
      d_row[k]  = d_off[DROW_W+1:2];
      p_wdat[k] = a_wd_q[7:0];
      d_wdat[k] = a_wd_q[7:0];
      port_d[k] = port_q[k];
    end

    case (a_op_q)
      OP_FETCH: begin
        if (a_addr_q == 32'd0) begin
          st = ST_HALT;
        end else if (misal) begin
          st = ST_MISALIGNED;
        end else if (in_prog4) begin
          rsel = RS_PWORD;
        end else begin
          st = fail_st;
        end
      end
      OP_LOAD_WORD: begin
        if (misal) begin
          st = ST_MISALIGNED;
        end else if (in_prog4) begin
          rsel = RS_PWORD;
        end else if (in_data4) begin
          rsel = RS_DWORD;
        end else if (a_addr_q == IN_BASE) begin
          con_rd = 1'b1;
        end else begin
          st = fail_st;
        end
      end
      OP_LOAD_BYTE: begin
        if (in_prog1) begin
          rsel = RS_PBYTE;
        end else if (in_data1) begin
          rsel = RS_DBYTE;
        end else if (in_input) begin
          con_rd = 1'b1;
        end else begin
          st = fail_st;
        end
      end
      OP_STORE_WORD: begin
        if (misal) begin
          st = ST_MISALIGNED;
        end else if (in_data4) begin
          d_we = 4'hF;
          for (int k = 0; k < 4; k++) begin
            d_wdat[k] = a_wd_q[31-8*k -: 8];
          end
        end else if (a_addr_q == OUT_BASE) begin
          for (int k = 0; k < 4; k++) begin
            port_d[k] = a_wd_q[31-8*k -: 8];
          end
          emit = 1'b1;
        end else begin
          st = fail_st;
        end
      end
      OP_STORE_BYTE: begin
        if (in_data1) begin
          d_we[d_off[1:0]] = 1'b1;
        end else if (in_output) begin
          port_d[a_addr_q[1:0]] = a_wd_q[7:0];
          emit = 1'b1;
        end else begin
          st = fail_st;
        end
      end
      OP_STORE_HALF: begin
        if (in_output) begin
          port_d[a_addr_q[1:0]] = a_wd_q[7:0];
          emit = 1'b1;
        end else if (!in_data1) begin
          st = fail_st;
        end else if (!in_data1_nxt) begin
          st = fail_st_nxt;
        end else begin
          // high byte at the address, low byte at the next; may cross a row
          d_we[d_off[1:0]]       = 1'b1;
          d_wdat[d_off[1:0]]     = a_wd_q[15:8];
          d_we[d_off_nxt[1:0]]   = 1'b1;
          d_row[d_off_nxt[1:0]]  = d_off_nxt[DROW_W+1:2];
          d_wdat[d_off_nxt[1:0]] = a_wd_q[7:0];
        end
      end
      OP_PROG_BYTE: begin
        if (in_prog1) begin
          p_we[p_off[1:0]] = 1'b1;
        end else begin
          st = fail_st;
        end
      end
      OP_CHAR_IN: begin
        cchar_d = a_ic_q;
      end
      default: begin
        st = ST_OK;
      end
    endcase

    // console read handshake: first read arms, second returns the character
    pend_d = pend_q;
    rlit   = 8'd0;
    if (con_rd) begin
      if (!pend_q) begin
        pend_d = 1'b1;
        st     = ST_PENDING;
      end else begin
        pend_d = 1'b0;
        rlit   = cchar_q;
        st     = ST_CONSOLE;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stores: four byte lanes each; the clearing pass takes the ports after reset
  // --------------------------------------------------------------------------
  logic              do_item;
  logic              clr_prog, clr_data;
  logic [7:0]        p_rd [4];
  logic [7:0]        d_rd [4];
  logic              ram_en;
  logic [3:0]        p_we_m, d_we_m;
  logic [PROW_W-1:0] p_addr_m [4];
  logic [DROW_W-1:0] d_addr_m [4];
  logic [7:0]        p_wd_m [4];
  logic [7:0]        d_wd_m [4];

  assign do_item  = a_valid_q && adv;
  assign clr_prog = clr_busy_q && ({1'b0, clr_cnt_q} < (CLR_W + 1)'(PROG_ROWS));
  assign clr_data = clr_busy_q && ({1'b0, clr_cnt_q} < (CLR_W + 1)'(DATA_ROWS));
  assign ram_en   = adv || clr_busy_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (clr_busy_q) begin
        p_we_m[k]   = clr_prog;
        d_we_m[k]   = clr_data;
        p_addr_m[k] = clr_cnt_q[PROW_W-1:0];
        d_addr_m[k] = clr_cnt_q[DROW_W-1:0];
        p_wd_m[k]   = 8'd0;
        d_wd_m[k]   = 8'd0;
      end else begin
        p_we_m[k]   = p_we[k] && do_item;
        d_we_m[k]   = d_we[k] && do_item;
        p_addr_m[k] = p_row[k];
        d_addr_m[k] = d_row[k];
        p_wd_m[k]   = p_wdat[k];
        d_wd_m[k]   = d_wdat[k];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    mmbc_ram #(
      .DEPTH (PROG_ROWS)
    ) u_prog (
      .clk_i   (clk_i),
      .en_i    (ram_en),
      .we_i    (p_we_m[g]),
      .addr_i  (p_addr_m[g]),
      .wdata_i (p_wd_m[g]),
      .rdata_o (p_rd[g])
    );
    mmbc_ram #(
      .DEPTH (DATA_ROWS)
    ) u_data (
      .clk_i   (clk_i),
      .en_i    (ram_en),
      .we_i    (d_we_m[g]),
      .addr_i  (d_addr_m[g]),
      .wdata_i (d_wd_m[g]),
      .rdata_o (d_rd[g])
    );
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == CLR_W'(CLR_ROWS - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      pend_q    <= 1'b0;
      cchar_q   <= 8'd0;
      for (int k = 0; k < 4; k++) begin
        port_q[k] <= 8'd0;
      end
    end else if (adv) begin
      a_valid_q <= in_valid_i && !clr_busy_q;
      b_valid_q <= a_valid_q;
      if (a_valid_q) begin
        pend_q  <= pend_d;
        cchar_q <= cchar_d;
        for (int k = 0; k < 4; k++) begin
          port_q[k] <= port_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_op_q        <= op_e'(op_i);
      a_addr_q      <= address_i;
      a_wd_q        <= write_data_i;
      a_ic_q        <= input_char_i;
      b_status_q    <= st;
      b_rsel_q      <= rsel;
      b_lane_q      <= a_addr_q[1:0];
      b_rlit_q      <= rlit;
      b_putc_q      <= emit;
      b_putc_char_q <= emit ? port_d[3] : 8'd0;
    end
  end

  // --------------------------------------------------------------------------
  // Result
  // --------------------------------------------------------------------------
  always_comb begin
    case (b_rsel_q)
      RS_PWORD: read_data_o = {p_rd[0], p_rd[1], p_rd[2], p_rd[3]};
      RS_DWORD: read_data_o = {d_rd[0], d_rd[1], d_rd[2], d_rd[3]};
      RS_PBYTE: read_data_o = {24'd0, p_rd[b_lane_q]};
      RS_DBYTE: read_data_o = {24'd0, d_rd[b_lane_q]};
      default:  read_data_o = {24'd0, b_rlit_q};
    endcase
  end

  assign out_valid_o  = b_valid_q;
  assign status_o     = b_status_q;
  assign putc_valid_o = b_putc_q;
  assign putc_char_o  = b_putc_char_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_req_during_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> in_stall_o)
    else $error("request taken during store clearing");

  a_putc_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && putc_valid_o) |-> (status_o == ST_OK))
    else $error("putc with non-ok status");

  a_putc_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && putc_valid_o) |-> (putc_char_o == port_q[3]))
    else $error("putc char differs from port byte 3");

  a_console_arm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_item && con_rd && !pend_q) |=> (pend_q && status_o == ST_PENDING))
    else $error("console read did not arm pending");

endmodule : memory_map_bus_with_console_unit
`default_nettype wire
